// File: sv/ipff_pkg.sv
// Shared types, codes and character helpers for the integer printf field formatter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ipff_pkg;

  // Conversion kinds carried on the input tuser.
  localparam logic [2:0] FUNC_DEC    = 3'd0;
  localparam logic [2:0] FUNC_UDEC   = 3'd1;
  localparam logic [2:0] FUNC_OCT    = 3'd2;
  localparam logic [2:0] FUNC_HEX_LO = 3'd3;
  localparam logic [2:0] FUNC_HEX_UP = 3'd4;
  localparam logic [2:0] FUNC_PTR    = 3'd5;

  // Length modifiers; any other code behaves as a plain 32-bit int.
  localparam logic [1:0] LM_INT   = 2'd0;
  localparam logic [1:0] LM_SHORT = 2'd1;
  localparam logic [1:0] LM_LONG  = 2'd2;

  localparam int DIGITS     = 24;  // digit store depth
  localparam int BCD_DIGITS = 20;  // decimal digits of a 64-bit value
  localparam int CONV_STEPS = 64;  // shift-and-add-3 steps for 64 bits

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_LOWER_I = 8'h69;
  localparam logic [7:0] CH_LOWER_L = 8'h6C;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the accepted request
    logic conv_step;  // one binary-to-BCD step
    logic count;      // fill the digit store and count digits
    logic size;       // work out zero and space padding
    logic layout;     // work out segment boundaries of the field
    logic emit;       // load the next character into the output register
  } ipff_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_conv;  // decimal request: run the BCD conversion
    logic conv_last;  // the current conversion step is the final one
    logic emit_last;  // the character being emitted is the final one
    logic out_free;   // the output register can take a character
  } ipff_sts_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base_ch;
    base_ch = upper ? CH_UPPER_A : CH_LOWER_A;
    if (d < 4'd10) begin
      return CH_ZERO + {4'b0000, d};
    end
    return base_ch + {4'b0000, d} - 8'd10;
  endfunction

  function automatic logic [7:0] nil_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0: ch = CH_LPAREN;
      3'd1: ch = CH_LOWER_N;
      3'd2: ch = CH_LOWER_I;
      3'd3: ch = CH_LOWER_L;
      3'd4: ch = CH_RPAREN;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: sv/ipff_ctrl.sv
// Controller state machine of the integer printf field formatter.
// Depends on ipff_pkg for the command and status structs.
`default_nettype none

module ipff_ctrl
  import ipff_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  output logic           s_tready,
  input  wire ipff_sts_t sts,
  output ipff_cmd_t      cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CONV   = 6'b000010,
    S_COUNT  = 6'b000100,
    S_SIZE   = 6'b001000,
    S_LAYOUT = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        if (!sts.need_conv) begin
          state_next = S_COUNT;
        end else begin
          cmd.conv_step = 1'b1;
          if (sts.conv_last) begin
            state_next = S_COUNT;
          end
        end
      end
      S_COUNT: begin
        cmd.count  = 1'b1;
        state_next = S_SIZE;
      end
      S_SIZE: begin
        cmd.size   = 1'b1;
        state_next = S_LAYOUT;
      end
      S_LAYOUT: begin
        cmd.layout = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/ipff_dp.sv
// Datapath of the integer printf field formatter: request capture, BCD conversion,
// digit store, padding arithmetic and the output register. Depends on ipff_pkg.
`default_nettype none

module ipff_dp
  import ipff_pkg::*;
#(
  parameter int MAX_OUTPUT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ipff_cmd_t   cmd,
  output ipff_sts_t        sts,
  input  wire logic [87:0] s_tdata,
  input  wire logic [7:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tlast,
  output logic             m_tuser
);

  localparam logic [8:0] MAX_W = 9'(MAX_OUTPUT);

  // Request fields.
  logic [2:0]  func_in;
  logic [1:0]  lm_in;
  logic [63:0] val_in;
  logic        alt_in, zero_in, left_in, space_in, plus_in, dot_in;
  logic [5:0]  prec_in;
  logic [6:0]  wid_in;

  assign func_in  = s_tuser[2:0];
  assign lm_in    = s_tuser[4:3];
  assign val_in   = s_tdata[63:0];
  assign alt_in   = s_tdata[64];
  assign zero_in  = s_tdata[65];
  assign left_in  = s_tdata[66];
  assign space_in = s_tdata[67];
  assign plus_in  = s_tdata[68];
  assign dot_in   = s_tdata[69];
  assign prec_in  = s_tdata[75:70];
  assign wid_in   = s_tdata[82:76];

  // Truncate per length modifier and take the magnitude of a negative d value.
  logic [1:0]  lm_eff;
  logic [63:0] mask_c, vmask_c, v_c;
  logic        msb_c, neg_c;

  always_comb begin
    lm_eff = (func_in == FUNC_PTR) ? LM_LONG : lm_in;
    case (lm_eff)
      LM_SHORT: begin
        mask_c = {48'b0, 16'hFFFF};
        msb_c  = val_in[15];
      end
      LM_LONG: begin
        mask_c = '1;
        msb_c  = val_in[63];
      end
      default: begin
        mask_c = {32'b0, 32'hFFFF_FFFF};
        msb_c  = val_in[31];
      end
    endcase
    vmask_c = val_in & mask_c;
    neg_c   = (func_in == FUNC_DEC) && msb_c;
    v_c     = neg_c ? ((~vmask_c + 64'd1) & mask_c) : vmask_c;
  end

  // Captured request.
  logic [63:0] v;
  logic        sign, alt, zflag, left, dot, upper, bad;
  logic        is_dec, is_oct, is_hex, is_ptr;
  logic [7:0]  sign_ch;
  logic [5:0]  prec;
  logic [6:0]  wid;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v       <= v_c;
      sign    <= (func_in == FUNC_DEC) && (neg_c || plus_in || space_in);
      sign_ch <= neg_c ? CH_MINUS : (plus_in ? CH_PLUS : CH_SPACE);
      alt     <= (func_in == FUNC_PTR) || ((func_in != FUNC_UDEC) && alt_in);
      zflag   <= zero_in & ~left_in;
      left    <= left_in;
      dot     <= dot_in;
      prec    <= prec_in;
      wid     <= wid_in;
      upper   <= (func_in == FUNC_HEX_UP);
      bad     <= (func_in > FUNC_PTR);
      is_dec  <= (func_in == FUNC_DEC) || (func_in == FUNC_UDEC);
      is_oct  <= (func_in == FUNC_OCT);
      is_hex  <= (func_in >= FUNC_HEX_LO);
      is_ptr  <= (func_in == FUNC_PTR);
    end
  end

  // Shift-and-add-3 conversion, one bit of the value per step.
  logic [63:0]               work_value;
  logic [4*BCD_DIGITS-1:0]   bcd, bcd_adj;
  logic [5:0]                conv_cnt;

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work_value <= v_c;
      bcd        <= '0;
      conv_cnt   <= '0;
    end else if (cmd.conv_step) begin
      bcd        <= {bcd_adj[4*BCD_DIGITS-2:0], work_value[63]};
      work_value <= {work_value[62:0], 1'b0};
      conv_cnt   <= conv_cnt + 6'd1;
    end
  end

  // Digit store fill and digit count.
  logic [4*DIGITS-1:0] bcd_ext, hex_ext, oct_ext, fill;
  logic [71:0]         oct_src;
  logic [4:0]          nd_c;
  logic                vzero, nil_c, zp_c;

  always_comb begin
    bcd_ext = {{(4*DIGITS-4*BCD_DIGITS){1'b0}}, bcd};
    hex_ext = {32'b0, v};
    oct_src = {8'b0, v};
    for (int i = 0; i < DIGITS; i++) begin
      oct_ext[4*i +: 4] = {1'b0, oct_src[3*i +: 3]};
    end
    fill = is_dec ? bcd_ext : (is_oct ? oct_ext : hex_ext);
    nd_c = 5'd1;
    for (int i = 1; i < DIGITS; i++) begin
      if (fill[4*i +: 4] != 4'd0) begin
        nd_c = 5'(i + 1);
      end
    end
    vzero = (v == 64'd0);
    nil_c = is_ptr && vzero;
    zp_c  = dot && (prec == 6'd0) && vzero && !(is_oct && alt);
  end

  logic [3:0] digit_store [DIGITS];
  logic [4:0] nd;
  logic       nil, pfx, octz;

  always_ff @(posedge clk) begin
    if (cmd.count) begin
      for (int i = 0; i < DIGITS; i++) begin
        digit_store[i] <= fill[4*i +: 4];
      end
      nd   <= nil_c ? 5'd5 : (zp_c ? 5'd0 : nd_c);
      nil  <= nil_c;
      pfx  <= is_hex && alt && !vzero;
      octz <= is_oct && alt && !vzero;
    end
  end

  // Padding sizes.
  logic [5:0] n_c, fixed_c;
  logic [6:0] zeros_c, spaces_c, zeros, spaces;
  logic [7:0] used_c;

  always_comb begin
    n_c     = {1'b0, nd} + {5'b0, octz};
    fixed_c = n_c + {5'b0, sign} + (pfx ? 6'd2 : 6'd0);
    zeros_c = '0;
    if (nil) begin
      zeros_c = '0;
    end else if (dot) begin
      if (prec > n_c) begin
        zeros_c = {1'b0, prec - n_c};
      end
    end else if (zflag) begin
      if (wid > {1'b0, fixed_c}) begin
        zeros_c = wid - {1'b0, fixed_c};
      end
    end
    used_c   = {2'b0, fixed_c} + {1'b0, zeros_c};
    spaces_c = ({1'b0, wid} > used_c) ? 7'({1'b0, wid} - used_c) : 7'd0;
  end

  always_ff @(posedge clk) begin
    if (cmd.size) begin
      zeros  <= zeros_c;
      spaces <= spaces_c;
    end
  end

  // Segment boundaries: left spaces, sign, prefix, zeros, octal zero, digits, right spaces.
  logic [7:0] b1_c, b2_c, b3_c, b4_c, b5_c, b6_c, total_c, nout_c;
  logic       empty_c;
  logic [7:0] b1, b2, b3, b4, b5, b6, nout;
  logic       empty;

  always_comb begin
    b1_c    = left ? 8'd0 : {1'b0, spaces};
    b2_c    = b1_c + {7'b0, sign};
    b3_c    = b2_c + (pfx ? 8'd2 : 8'd0);
    b4_c    = b3_c + {1'b0, zeros};
    b5_c    = b4_c + {7'b0, octz};
    b6_c    = b5_c + {3'b0, nd};
    total_c = b6_c + (left ? {1'b0, spaces} : 8'd0);
    empty_c = bad || (total_c == 8'd0);
    if (empty_c) begin
      nout_c = 8'd1;
    end else if ({1'b0, total_c} > MAX_W) begin
      nout_c = MAX_W[7:0];
    end else begin
      nout_c = total_c;
    end
  end

  logic [7:0] pos;

  always_ff @(posedge clk) begin
    if (cmd.layout) begin
      b1    <= b1_c;
      b2    <= b2_c;
      b3    <= b3_c;
      b4    <= b4_c;
      b5    <= b5_c;
      b6    <= b6_c;
      nout  <= nout_c;
      empty <= empty_c;
      pos   <= '0;
    end else if (cmd.emit) begin
      pos   <= pos + 8'd1;
    end
  end

  // Character at the current position.
  logic [7:0] dig_off, nil_off, ch_c;
  logic [4:0] dig_idx;
  logic [3:0] dig_val;
  logic       emit_last_c;

  always_comb begin
    dig_off = b6 - 8'd1 - pos;
    dig_idx = dig_off[4:0];
    dig_val = (dig_idx < 5'(DIGITS)) ? digit_store[dig_idx] : 4'd0;
    nil_off = pos - b5;
    if (empty) begin
      ch_c = CH_NUL;
    end else if (pos < b1) begin
      ch_c = CH_SPACE;
    end else if (pos < b2) begin
      ch_c = sign_ch;
    end else if (pos < b3) begin
      ch_c = (pos == b2) ? CH_ZERO : (upper ? CH_UPPER_X : CH_LOWER_X);
    end else if (pos < b5) begin
      ch_c = CH_ZERO;
    end else if (pos < b6) begin
      ch_c = nil ? nil_char(nil_off[2:0]) : digit_char(dig_val, upper);
    end else begin
      ch_c = CH_SPACE;
    end
    emit_last_c = ((pos + 8'd1) == nout);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= ch_c;
      m_tlast <= emit_last_c;
      m_tuser <= empty;
    end
  end

  always_comb begin
    sts.need_conv = is_dec && !bad;
    sts.conv_last = (conv_cnt == 6'(CONV_STEPS - 1));
    sts.emit_last = emit_last_c;
    sts.out_free  = !m_tvalid || m_tready;
  end

endmodule

`default_nettype wire

// File: sv/integer_printf_field_formatter_unit.sv
// Top level of the integer printf field formatter: controller plus datapath.
// Depends on ipff_pkg, ipff_ctrl and ipff_dp.
//
// Usage: one item on the slave stream is one integer conversion request; the block
// answers with its printf-style text on the master stream, one character per item,
// with tlast on the final character. A request whose field has no characters gives
// a single item with character 0, tlast high and tuser high.
// Sequence: the request is captured in its accept cycle. Decimal kinds then run a
// 64-step shift-and-add-3 conversion, one step per cycle; other kinds pass through
// the conversion state without a step. Then the digit count, padding sizing and
// field layout steps follow in turn before the first character enters the output
// register. After that one character is produced per cycle unless the output
// stalls, up to MAX_OUTPUT characters (longer fields are cut, tlast on the last kept).
// Requests: one request at a time. s_tready rises again in the cycle after the final
// character is loaded, while that character may still wait in the output register.
// Stalls: when m_tready is low the current character holds in the output register
// and the character sequencer waits; nothing is dropped.
// Reset: rst (synchronous, active high) empties the output register and returns the
// controller to idle, ready for a request.
`default_nettype none

module integer_printf_field_formatter_unit
  import ipff_pkg::*;
#(
  parameter int MAX_OUTPUT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // From bit 0: value[63:0], flag_alt, flag_zero, flag_left, flag_space, flag_plus,
  // has_precision, precision[5:0], width[6:0], then zero fill to 88 bits.
  input  wire logic [87:0] s_tdata,
  // From bit 0: func[2:0], length_mod[1:0], then zero fill to 8 bits.
  input  wire logic [7:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // From bit 0: out_char[7:0].
  output logic [7:0]       m_tdata,
  // last: final character of the field.
  output logic             m_tlast,
  // empty_res: the field has no characters.
  output logic             m_tuser
);

  ipff_cmd_t cmd;
  ipff_sts_t sts;

  ipff_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ipff_dp #(
    .MAX_OUTPUT (MAX_OUTPUT)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

`ifndef SYNTHESIS
  // An empty field is always a single, final item with a zero character.
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'h00))
    else $error("empty result without tlast or with a nonzero character");

  // One request at a time: no second accept right after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a request is in progress");

  // Loading the final character frees the block for the next request.
  a_free_after_last: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && sts.emit_last |=> s_tready && m_tvalid && m_tlast)
    else $error("block not ready after the final character");
`endif

endmodule

`default_nettype wire

// File: verif/integer_printf_field_formatter_unit_test.sv
// Self-checking testbench for integer_printf_field_formatter_unit: a directed table, then
// random requests, with every character checked against typed text or a local predictor.
// Depends on ipff_pkg and the formatter RTL only.
`default_nettype none

module integer_printf_field_formatter_unit_test;
  import ipff_pkg::*;

  localparam int MAX_CHARS      = 64;
  localparam int DIRECTED_ROWS  = 25;
  localparam int RANDOM_PER_PHASE = 67;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 200;

  // Kind and length codes that the block must treat as unknown.
  localparam logic [2:0] FUNC_UNUSED_LO = 3'd6;
  localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;
  localparam logic [1:0] LM_UNUSED      = 2'd3;

  // Marks a table row whose characters come from the predictor instead of typed text.
  localparam string FROM_PREDICTOR = "?";

  // One conversion request, fields in the order used by the directed table.
  typedef struct packed {
    logic [2:0]  func;
    logic [1:0]  lm;
    logic [63:0] value;
    logic        alt;
    logic        zero;
    logic        left;
    logic        spc;
    logic        plus;
    logic        dot;
    logic [5:0]  prec;
    logic [6:0]  wid;
  } request_t;

  // One output item as seen on the master stream.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       empty;
  } field_char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata = '0;
  logic [7:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        m_tuser;

  integer_printf_field_formatter_unit #(
    .MAX_OUTPUT(MAX_CHARS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  always #6 clk = ~clk;

  // Characters still owed by the block, oldest first.
  field_char_t expected_chars[$];

  int src_idle_pct  = 26;
  int sink_idle_pct = 70;
  int requests_sent = 0;
  int chars_checked = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;

  // Directed table. Rows with typed text are read straight off the printf rules; rows
  // marked FROM_PREDICTOR are too long to type by hand.
  // Fields: func, lm, value, alt, zero, left, spc, plus, dot, prec, wid.
  request_t directed_req [DIRECTED_ROWS] = '{
    '{FUNC_DEC,       LM_INT,    64'd0,                  0, 0, 0, 0, 0, 0, 6'd0,  7'd0},
    '{FUNC_DEC,       LM_INT,    64'hFFFF_FFFF,          0, 0, 0, 0, 0, 0, 6'd0,  7'd0},
    '{FUNC_DEC,       LM_INT,    64'hFFFF_FFFF_8000_0000, 0, 0, 0, 0, 0, 0, 6'd0,  7'd0},
    '{FUNC_DEC,       LM_LONG,   64'h8000_0000_0000_0000, 0, 0, 0, 0, 0, 0, 6'd0,  7'd0},
    '{FUNC_DEC,       LM_SHORT,  64'h0000_0000_0001_8000, 0, 0, 0, 0, 0, 0, 6'd0,  7'd0},
    '{FUNC_UDEC,      LM_LONG,   64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 0, 0, 0, 0, 6'd0,  7'd0},
    '{FUNC_OCT,       LM_LONG,   64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0, 6'd0,  7'd0},
    '{FUNC_HEX_LO,    LM_LONG,   64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 0, 0, 0, 0, 6'd0,  7'd0},
    '{FUNC_HEX_UP,    LM_SHORT,  64'h0000_0000_0000_BEEF, 1, 1, 0, 0, 0, 0, 6'd0,  7'd10},
    '{FUNC_HEX_LO,    LM_INT,    64'h0000_0000_0000_00AB, 1, 0, 0, 0, 0, 1, 6'd4,  7'd0},
    '{FUNC_HEX_LO,    LM_INT,    64'd0,                  1, 0, 0, 0, 0, 0, 6'd0,  7'd0},
    '{FUNC_PTR,       LM_INT,    64'd0,                  0, 0, 0, 0, 0, 0, 6'd0,  7'd8},
    '{FUNC_PTR,       LM_INT,    64'd0,                  0, 1, 1, 0, 0, 1, 6'd5,  7'd8},
    '{FUNC_PTR,       LM_SHORT,  64'h0000_0000_0000_1234, 0, 0, 0, 0, 0, 0, 6'd0,  7'd0},
    '{FUNC_DEC,       LM_INT,    64'd0,                  0, 0, 0, 0, 0, 1, 6'd0,  7'd0},
    '{FUNC_DEC,       LM_INT,    64'd0,                  0, 0, 0, 0, 1, 1, 6'd0,  7'd0},
    '{FUNC_OCT,       LM_INT,    64'd0,                  1, 0, 0, 0, 0, 1, 6'd0,  7'd0},
    '{FUNC_DEC,       LM_INT,    64'd5,                  0, 0, 0, 1, 1, 0, 6'd0,  7'd0},
    '{FUNC_DEC,       LM_INT,    64'd42,                 0, 0, 0, 1, 0, 0, 6'd0,  7'd0},
    '{FUNC_DEC,       LM_INT,    64'd42,                 0, 1, 1, 0, 0, 0, 6'd0,  7'd6},
    '{FUNC_DEC,       LM_INT,    64'd42,                 0, 1, 0, 0, 0, 1, 6'd5,  7'd8},
    '{FUNC_DEC,       LM_UNUSED, 64'h0000_0001_0000_007B, 0, 0, 0, 0, 0, 0, 6'd0,  7'd0},
    '{FUNC_UNUSED_LO, LM_INT,    64'd77,                 1, 1, 0, 1, 1, 1, 6'd3,  7'd9},
    '{FUNC_UNUSED_HI, LM_LONG,   64'hFFFF_FFFF_FFFF_FFFF, 1, 1, 1, 1, 1, 1, 6'd63, 7'd127},
    '{FUNC_DEC,       LM_LONG,   64'hFFFF_FFFF_FFFF_FFFF, 1, 1, 1, 1, 1, 1, 6'd63, 7'd127}
  };

  // Expected text per row; an empty string means the single empty item.
  string directed_text [DIRECTED_ROWS] = '{
    "0",
    "-1",
    "-2147483648",
    "-9223372036854775808",
    "-32768",
    "18446744073709551615",
    "1777777777777777777777",
    "0xffffffffffffffff",
    "0X0000BEEF",
    "0x00ab",
    "0",
    "   (nil)",
    "(nil)   ",
    "0x1234",
    "",
    "+",
    "0",
    "+5",
    " 42",
    "42    ",
    "   00042",
    "123",
    "",
    "",
    FROM_PREDICTOR
  };

  // Works out the characters that one request must produce and queues them. The field is
  // laid out as: leading spaces, sign or prefix, zero padding, digits, trailing spaces,
  // then cut to MAX_CHARS with the final kept character marked last.
  function automatic void predict_field(input request_t r);
    logic [1:0]  lm;
    logic [63:0] mask;
    logic [63:0] v;
    logic [63:0] rest;
    logic [7:0]  sign_ch;
    logic [7:0]  text[$];
    logic [3:0]  digs[$];
    logic        upper;
    logic        alt;
    logic        pfx;
    logic        octz;
    logic        nil;
    int          bits;
    int          base;
    int          sign;
    int          n;
    int          pw;
    int          zeros;
    int          spaces;
    int          wid;
    int          kept;
    wid = int'(r.wid);
    if (r.func > FUNC_PTR) begin
      expected_chars.push_back('{CH_NUL, 1'b1, 1'b1});
      return;
    end
    // Pointers are always full 64-bit; unknown length codes act as plain int.
    lm = (r.func == FUNC_PTR) ? LM_LONG : r.lm;
    bits = (lm == LM_SHORT) ? 16 : (lm == LM_LONG) ? 64 : 32;
    mask = (bits == 64) ? '1 : ((64'd1 << bits) - 64'd1);
    v = r.value & mask;
    sign = 0;
    sign_ch = CH_NUL;
    if (r.func == FUNC_DEC) begin
      if (v[bits-1]) begin
        v = (~v + 64'd1) & mask;
        sign = 1;
        sign_ch = CH_MINUS;
      end else if (r.plus) begin
        sign = 1;
        sign_ch = CH_PLUS;
      end else if (r.spc) begin
        sign = 1;
        sign_ch = CH_SPACE;
      end
    end
    base = (r.func <= FUNC_UDEC) ? 10 : (r.func == FUNC_OCT) ? 8 : 16;
    upper = (r.func == FUNC_HEX_UP);
    alt = (r.func == FUNC_PTR) ? 1'b1 : (r.func == FUNC_UDEC) ? 1'b0 : r.alt;
    nil = (r.func == FUNC_PTR) && (v == 0);
    pfx = 1'b0;
    octz = 1'b0;
    // A zero precision on a zero value drops the digits, unless octal with the hash flag.
    if (!nil && !(r.dot && r.prec == 0 && v == 0 && !(r.func == FUNC_OCT && alt))) begin
      rest = v;
      do begin
        digs.push_back(4'(rest % base));
        rest = rest / base;
      end while (rest != 0);
      octz = (r.func == FUNC_OCT) && alt && (v != 0);
      pfx = (r.func >= FUNC_HEX_LO) && alt && (v != 0);
    end
    if (nil) begin
      spaces = (wid > 5) ? wid - 5 : 0;
      if (!r.left) repeat (spaces) text.push_back(CH_SPACE);
      text.push_back(CH_LPAREN);
      text.push_back(CH_LOWER_N);
      text.push_back(CH_LOWER_I);
      text.push_back(CH_LOWER_L);
      text.push_back(CH_RPAREN);
      if (r.left) repeat (spaces) text.push_back(CH_SPACE);
    end else begin
      pw = pfx ? 2 : 0;
      n = digs.size() + (octz ? 1 : 0);
      zeros = 0;
      if (r.dot) begin
        if (int'(r.prec) > n) zeros = int'(r.prec) - n;
      end else if (r.zero && !r.left && wid > n + sign + pw) begin
        zeros = wid - n - sign - pw;
      end
      spaces = wid - sign - pw - zeros - n;
      if (spaces < 0) spaces = 0;
      if (!r.left) repeat (spaces) text.push_back(CH_SPACE);
      if (sign != 0) text.push_back(sign_ch);
      if (pfx) begin
        text.push_back(CH_ZERO);
        text.push_back(upper ? CH_UPPER_X : CH_LOWER_X);
      end
      repeat (zeros) text.push_back(CH_ZERO);
      if (octz) text.push_back(CH_ZERO);
      for (int i = digs.size() - 1; i >= 0; i--) begin
        if (digs[i] < 4'd10) text.push_back(CH_ZERO + 8'(digs[i]));
        else text.push_back((upper ? CH_UPPER_A : CH_LOWER_A) + 8'(digs[i]) - 8'd10);
      end
      if (r.left) repeat (spaces) text.push_back(CH_SPACE);
    end
    if (text.size() == 0) begin
      expected_chars.push_back('{CH_NUL, 1'b1, 1'b1});
      return;
    end
    kept = (text.size() < MAX_CHARS) ? text.size() : MAX_CHARS;
    for (int i = 0; i < kept; i++) expected_chars.push_back('{text[i], i == kept - 1, 1'b0});
  endfunction

  // Offers one request on the slave stream, idling first at the current rate, and books
  // its characters once the item is taken. Called at a rising edge.
  task automatic send_request(input request_t r, input string text);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'b0, r.wid, r.prec, r.dot, r.plus, r.spc, r.left, r.zero, r.alt, r.value};
    s_tuser <= {3'b0, r.lm, r.func};
    do @(posedge clk); while (!s_tready);
    requests_sent++;
    if (text == FROM_PREDICTOR) begin
      predict_field(r);
    end else if (text.len() == 0) begin
      expected_chars.push_back('{CH_NUL, 1'b1, 1'b1});
    end else begin
      for (int i = 0; i < text.len(); i++) begin
        expected_chars.push_back('{8'(text[i]), i == text.len() - 1, 1'b0});
      end
    end
  endtask

  // Output checker and receiver pacing. Each accepted item is matched with the oldest
  // character still owed.
  always @(posedge clk) begin : check_output
    field_char_t got;
    field_char_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata, m_tlast, m_tuser};
      chars_checked++;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: unexpected item char=%h last=%b empty=%b",
                   got.ch, got.last, got.empty);
        end
      end else begin
        want = expected_chars.pop_front();
        if (got.ch !== want.ch || got.last !== want.last || got.empty !== want.empty) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: item %0d expected char=%h last=%b empty=%b, got char=%h last=%b empty=%b",
                     chars_checked, want.ch, want.last, want.empty,
                     got.ch, got.last, got.empty);
          end
        end
      end
    end
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Watchdog: a long stretch with no item moving on either side means the block hung.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no item moved for %0d cycles, %0d characters still owed",
                 WATCHDOG_LIMIT, expected_chars.size());
        $display("integer_printf_field_formatter_unit_test: done, errors");
        $finish;
      end
    end
  end

  // Stimulus: the directed table under the first pacing, then random requests in three
  // pacing phases (receiver idles more, sender idles more, no idling at all).
  initial begin : stimulus
    request_t req;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct  = (phase == 0) ? 26 : (phase == 1) ? 70 : 0;
      sink_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 26 : 0;
      if (phase == 0) begin
        for (int row = 0; row < DIRECTED_ROWS; row++) begin
          send_request(directed_req[row], directed_text[row]);
        end
      end
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        // Mostly valid kinds, now and then an unknown one.
        req.func = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
        req.lm = 2'($urandom_range(3));
        case ($urandom_range(4))
          0: req.value = 64'd0;
          1: req.value = 64'($urandom_range(99));
          2: req.value = {$urandom, $urandom};
          // Powers of two and one below them hit every sign boundary.
          3: req.value = (64'd1 << $urandom_range(63)) - 64'($urandom_range(1));
          default: req.value = '1 - 64'($urandom_range(99));
        endcase
        req.alt  = 1'($urandom_range(1));
        req.zero = 1'($urandom_range(1));
        req.left = 1'($urandom_range(1));
        req.spc  = 1'($urandom_range(1));
        req.plus = 1'($urandom_range(1));
        req.dot  = 1'($urandom_range(1));
        // Small sizes are typical; wide fields and long precisions test the 64-char cut.
        req.prec = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(10));
        req.wid  = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(24));
        send_request(req, FROM_PREDICTOR);
      end
    end
    s_tvalid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    // Stray characters after the last owed one would show up in this window.
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d requests (%0d from the directed table) across three pacing phases.",
             requests_sent, DIRECTED_ROWS);
    $display("Checked %0d output characters, %0d mismatches.", chars_checked, mismatches);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("integer_printf_field_formatter_unit_test: done, clean");
    end else begin
      $display("integer_printf_field_formatter_unit_test: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
